/* hw/rtl/stable_max_priority_queue_macros.svh */
// Assertion macros for the stable max-priority queue.
`ifndef STABLE_MAX_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_MAX_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPQ_ASSERT_ALWAYS(label, prop, msg)
`define SPQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hw/rtl/spq_pkg.sv */
// Types, codes and constants shared by the priority queue modules.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int SPQ_DEPTH = 64;

  localparam int REQ_W  = 2;
  localparam int TAG_W  = 16;
  localparam int PRIO_W = 32;
  localparam int STAT_W = 3;

  // Request codes; the unused fourth code behaves as a clear.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_POPPED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;

  // Command broadcast to every cell.
  localparam logic [1:0] OP_IDLE   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } spq_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } spq_entry_t;

  localparam spq_entry_t SPQ_NO_ENTRY = '{valid: 1'b0, tag: '0, prio: '0};

endpackage

`default_nettype wire

/* hw/rtl/spq_if.sv */
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if import spq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TAG_W-1:0]  tag;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, req_type, tag, priority_req, input ready);
  modport sink   (input valid, req_type, tag, priority_req, output ready);
endinterface

interface spq_out_if import spq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  out_tag;
  logic [PRIO_W-1:0] out_priority;

  modport source (output valid, status, out_tag, out_priority, input ready);
  modport sink   (input valid, status, out_tag, out_priority, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stable_max_priority_queue.sv */
// Top level of the stable max-priority queue built as a sorted row of cells.
//
//   channel  dir  beat contents
//   in_ch    in   req_type, tag, priority_req
//   out_ch   out  status, out_tag, out_priority
//
// Each request beat updates the whole cell row at its accepting edge and its
// result beat is registered for the next cycle; one beat per cycle unless out_ch stalls.
// The row is kept sorted, so the head cell always holds the entry to serve.
// A stalled result holds in_ch.ready low until the result beat is taken.
// Synchronous reset empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "stable_max_priority_queue_macros.svh"

module stable_max_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = SPQ_DEPTH
) (
  input wire logic clk,
  input wire logic rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);

  spq_cmd_t          cmd;
  spq_entry_t        ent [DEPTH];
  logic [DEPTH-1:0]  place_vec;
  logic [DEPTH-1:0]  valid_vec;
  logic              in_accept;
  logic              full;
  logic              empty;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign full        = valid_vec[DEPTH-1];
  assign empty       = !valid_vec[0];

  always_comb begin
    cmd.op     = OP_IDLE;
    cmd.tag    = in_ch.tag;
    cmd.prio   = in_ch.priority_req;
    status_nxt = status_r;
    tag_nxt    = tag_r;
    prio_nxt   = prio_r;
    if (in_accept) begin
      tag_nxt  = '0;
      prio_nxt = '0;
      unique case (in_ch.req_type)
        REQ_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.op     = OP_INSERT;
            status_nxt = ST_INSERTED;
          end
        end
        REQ_POP: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.op     = OP_POP;
            status_nxt = ST_POPPED;
            tag_nxt    = ent[0].tag;
            prio_nxt   = ent[0].prio;
          end
        end
        default: begin
          cmd.op     = OP_CLEAR;
          status_nxt = ST_CLEARED;
        end
      endcase
    end
  end

  assign out_valid_nxt = in_accept || (out_valid_r && !out_ch.ready);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_ent;
    spq_entry_t right_ent;
    logic       left_place;

    if (i == 0) begin : g_head
      assign left_ent   = SPQ_NO_ENTRY;
      assign left_place = 1'b0;
    end else begin : g_body
      assign left_ent   = ent[i-1];
      assign left_place = place_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = SPQ_NO_ENTRY;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_ent   (left_ent),
      .left_place (left_place),
      .right_ent  (right_ent),
      .ent        (ent[i]),
      .place      (place_vec[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    tag_r    <= tag_nxt;
    prio_r   <= prio_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_tag      = tag_r;
  assign out_ch.out_priority = prio_r;

  // Live entries always fill a prefix of the row.
  `SPQ_ASSERT_ALWAYS(a_valid_prefix,
    ((valid_vec + 1'b1) & valid_vec) == '0, "live cells not contiguous")
  // The head cell never ranks below its neighbor.
  `SPQ_ASSERT_ALWAYS(a_head_sorted,
    !valid_vec[1] || !($signed(ent[1].prio) > $signed(ent[0].prio)), "row out of order")
  // A clear empties the row by the next cycle.
  `SPQ_ASSERT_NEXT(a_clear_empties,
    in_accept && in_ch.req_type != REQ_INSERT && in_ch.req_type != REQ_POP,
    valid_vec == '0, "clear left entries")
  // A pop on an empty row reports empty with a zero payload.
  `SPQ_ASSERT_NEXT(a_empty_pop,
    in_accept && in_ch.req_type == REQ_POP && empty,
    status_r == ST_EMPTY && tag_r == '0 && prio_r == '0, "bad empty pop result")

endmodule

`default_nettype wire

/* hw/rtl/spq_cell.sv */
// One cell of the sorted queue: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire spq_cmd_t   cmd,
  input  wire spq_entry_t left_ent,
  input  wire logic       left_place,
  input  wire spq_entry_t right_ent,
  output spq_entry_t      ent,
  output logic            place
);

  logic              valid_r, valid_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;

  // A new entry lands ahead of this one only on strictly higher priority, so
  // equal priorities stay in arrival order.
  assign place = !valid_r || ($signed(cmd.prio) > $signed(prio_r));
  assign ent   = '{valid: valid_r, tag: tag_r, prio: prio_r};

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    prio_nxt  = prio_r;
    unique case (cmd.op)
      OP_IDLE: begin
      end
      OP_INSERT: begin
        if (left_place) begin
          valid_nxt = left_ent.valid;
          tag_nxt   = left_ent.tag;
          prio_nxt  = left_ent.prio;
        end else if (place) begin
          valid_nxt = 1'b1;
          tag_nxt   = cmd.tag;
          prio_nxt  = cmd.prio;
        end
      end
      OP_POP: begin
        valid_nxt = right_ent.valid;
        tag_nxt   = right_ent.tag;
        prio_nxt  = right_ent.prio;
      end
      OP_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

endmodule

`default_nettype wire

/* sim/stable_max_priority_queue_test.sv */
// Self-checking testbench for the stable max-priority queue with a behavioral queue model.
`timescale 1ns / 1ps

module stable_max_priority_queue_test;
  import spq_pkg::*;

  // The fourth request code is not in the package; the block treats it as a clear.
  localparam logic [REQ_W-1:0] REQ_CLEAR_ALT = 2'd3;

  localparam int LIMIT_CYCLES = 200000;
  localparam int TARGET_REQS  = 1700;
  localparam int IDLE_PCT     = 36;
  localparam int CALM_LO      = 600;
  localparam int CALM_HI      = 1000;
  localparam int HOLD_A       = 22;
  localparam int HOLD_B       = 900;
  localparam int MAX_PRINTS   = 40;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    bit                hold;
  } req_beat_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } result_beat_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  stable_max_priority_queue u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Behavioral copy of the queue contents.
  logic signed [PRIO_W-1:0] q_prio [SPQ_DEPTH];
  logic [TAG_W-1:0]         q_tag [SPQ_DEPTH];
  logic [31:0]              q_stamp [SPQ_DEPTH];
  int                       q_fill = 0;
  logic [31:0]              next_stamp = '0;

  req_beat_t    pending_reqs [$];
  result_beat_t owed_results [$];
  req_beat_t    cur_req;
  result_beat_t due;
  int           gen_fill = 0;
  int           in_beats = 0;
  int           out_beats = 0;
  int           cycles = 0;
  int           mismatches = 0;

  function automatic result_beat_t serve_request(req_beat_t r);
    result_beat_t res;
    int           best;
    logic [31:0]  age_i;
    logic [31:0]  age_b;
    res.status = ST_CLEARED;
    res.tag    = '0;
    res.prio   = '0;
    case (r.kind)
      REQ_INSERT: begin
        if (q_fill >= SPQ_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          q_prio[q_fill]  = r.prio;
          q_tag[q_fill]   = r.tag;
          q_stamp[q_fill] = next_stamp;
          q_fill++;
          next_stamp++;
          res.status = ST_INSERTED;
        end
      end
      REQ_POP: begin
        if (q_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < q_fill; i++) begin
            // Equal priorities go to the oldest arrival, measured modulo 2^32.
            age_i = next_stamp - q_stamp[i];
            age_b = next_stamp - q_stamp[best];
            if (q_prio[i] > q_prio[best] || (q_prio[i] == q_prio[best] && age_i > age_b))
              best = i;
          end
          res.status = ST_POPPED;
          res.tag    = q_tag[best];
          res.prio   = q_prio[best];
          q_fill--;
          q_prio[best]  = q_prio[q_fill];
          q_tag[best]   = q_tag[q_fill];
          q_stamp[best] = q_stamp[q_fill];
        end
      end
      default: begin
        q_fill     = 0;
        next_stamp = '0;
      end
    endcase
    return res;
  endfunction

  task automatic add_req(logic [REQ_W-1:0] kind, logic [TAG_W-1:0] tag,
                         logic [PRIO_W-1:0] prio);
    req_beat_t r;
    r.kind = kind;
    r.tag  = tag;
    r.prio = prio;
    r.hold = (pending_reqs.size() == HOLD_A || pending_reqs.size() == HOLD_B);
    pending_reqs.push_back(r);
    if (kind == REQ_INSERT) begin
      if (gen_fill < SPQ_DEPTH) gen_fill++;
    end else if (kind == REQ_POP) begin
      if (gen_fill > 0) gen_fill--;
    end else begin
      gen_fill = 0;
    end
  endtask

  // Mostly a narrow band so that ties are common, plus extremes and full-range values.
  function automatic logic [PRIO_W-1:0] pick_prio();
    int m;
    m = $urandom_range(9);
    if (m < 5) return PRIO_W'(int'($urandom_range(6)) - 3);
    if (m < 7) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("stable_max_priority_queue_test: FAIL");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        owed_results.push_back(serve_request(cur_req));
        in_beats++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() == 0 ||
            (pending_reqs[0].hold && owed_results.size() != 0) ||
            ((in_beats < CALM_LO || in_beats >= CALM_HI) &&
             $urandom_range(99) < IDLE_PCT)) begin
          in_ch.valid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.req_type     <= cur_req.kind;
          in_ch.tag          <= cur_req.tag;
          in_ch.priority_req <= cur_req.prio;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_beats++;
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing owed, status %0d", out_ch.status));
        end else begin
          due = owed_results.pop_front();
          if (out_ch.status !== due.status)
            flag_mismatch($sformatf("beat %0d status %0d, want %0d",
                                    out_beats, out_ch.status, due.status));
          if (out_ch.out_tag !== due.tag)
            flag_mismatch($sformatf("beat %0d tag %h, want %h",
                                    out_beats, out_ch.out_tag, due.tag));
          if (out_ch.out_priority !== due.prio)
            flag_mismatch($sformatf("beat %0d priority %h, want %h",
                                    out_beats, out_ch.out_priority, due.prio));
        end
      end
      out_ch.ready <= (out_beats >= CALM_LO && out_beats < CALM_HI) ||
                      ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int                n;
    int                pick;
    int                k;
    logic [REQ_W-1:0]  kind;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = REQ_INSERT;
    in_ch.tag           = '0;
    in_ch.priority_req  = '0;
    out_ch.ready        = 1'b0;

    // Directed: empty pop, field extremes, a three-way tie, drain past empty,
    // both clear codes.
    add_req(REQ_POP, 16'h0000, 32'h0000_0000);
    add_req(REQ_INSERT, 16'h0000, 32'h8000_0000);
    add_req(REQ_INSERT, 16'hffff, 32'h7fff_ffff);
    add_req(REQ_INSERT, 16'h1234, 32'h0000_0000);
    add_req(REQ_INSERT, 16'haaaa, 32'h0000_0005);
    add_req(REQ_INSERT, 16'h5555, 32'h0000_0005);
    add_req(REQ_INSERT, 16'h0001, 32'hffff_ffff);
    add_req(REQ_INSERT, 16'h0002, 32'h0000_0005);
    repeat (8) add_req(REQ_POP, 16'hffff, 32'hffff_ffff);
    add_req(REQ_INSERT, 16'h0007, 32'h0000_0003);
    add_req(REQ_CLEAR_ALT, 16'hffff, 32'hffff_ffff);
    add_req(REQ_POP, 16'h0000, 32'h0000_0000);
    add_req(REQ_INSERT, 16'h0009, 32'h0000_0001);
    add_req(REQ_CLEAR, 16'h0000, 32'h0000_0000);
    add_req(REQ_POP, 16'h0000, 32'h0000_0000);

    // Random: fill past full, drain past empty, mixed traffic and stray clears.
    while (pending_reqs.size() < TARGET_REQS) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        n = SPQ_DEPTH - gen_fill + $urandom_range(3);
        repeat (n) add_req(REQ_INSERT, TAG_W'($urandom), pick_prio());
      end else if (pick < 7) begin
        n = gen_fill + $urandom_range(2);
        repeat (n) add_req(REQ_POP, TAG_W'($urandom), $urandom);
      end else if (pick < 9) begin
        repeat (20) begin
          k = $urandom_range(19);
          if (k < 10)      kind = REQ_INSERT;
          else if (k < 18) kind = REQ_POP;
          else if (k < 19) kind = REQ_CLEAR;
          else             kind = REQ_CLEAR_ALT;
          add_req(kind, TAG_W'($urandom), pick_prio());
        end
      end else begin
        add_req($urandom_range(1) ? REQ_CLEAR : REQ_CLEAR_ALT, TAG_W'($urandom), $urandom);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_ch.valid) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("stable_max_priority_queue_test: PASS");
    end else begin
      $display("stable_max_priority_queue_test: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_max_priority_queue.sv
sim/stable_max_priority_queue_test.sv
